FILE: rtl/cmdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the command line tokenizer.
// Used by the controller, the datapath, the top level and the checker; no dependencies.

package cmdt_pkg;

   // Line buffer and argument limits
   localparam int MAX_LEN  = 32;
   localparam int MAX_ARGS = 8;

   // Derived widths
   localparam int POS_W = $clog2(MAX_LEN + 1);
   localparam int LB_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int AC_W  = $clog2(MAX_ARGS + 1);
   localparam int AS_AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

   // Fixed field widths
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int OFFSET_W = 6;
   localparam int COUNT_W  = 4;

   // Special characters
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      PH_TOKEN = 2'd0,
      PH_SPACE = 2'd1,
      PH_ENDL  = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO  = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_ARG   = 2'd2,
      KIND_BYTE  = 2'd3
   } kind_type;

   typedef enum logic {
      ERR_LINE_LONG = 1'b0,
      ERR_ARGS_MANY = 1'b1
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ECHO,
      ST_ERROR,
      ST_ARG_RD,
      ST_ARG_OUT,
      ST_BYTE_RD,
      ST_BYTE_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic eval;
      logic ld_echo;
      logic ld_err;
      logic ld_arg;
      logic ld_byte;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic echo_en;
      logic err_pend;
      logic dump_pend;
      logic arg_done;
      logic byte_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/cmdt_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module cmdt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cmdt_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the command line tokenizer.
// Depends on cmdt_pkg; drives commands into cmdt_datapath and reads its status.

module cmdt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cmdt_pkg::dp_status_type status,
   output cmdt_pkg::ctl_cmd_type   cmd
);

   import cmdt_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type after_echo;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Pick the step after the echo slot
   always_comb begin
      if (status.err_pend) begin
         after_echo = ST_ERROR;
      end else if (status.dump_pend) begin
         after_echo = ST_ARG_RD;
      end else begin
         after_echo = ST_IDLE;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_ECHO;
         end
         ST_ECHO: begin
            if (!status.echo_en) begin
               state_in = after_echo;
            end else if (status.out_free) begin
               cmd.ld_echo = 1'b1;
               state_in    = after_echo;
            end
         end
         ST_ERROR: begin
            if (status.out_free) begin
               cmd.ld_err = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_ARG_RD: begin
            state_in = ST_ARG_OUT;
         end
         ST_ARG_OUT: begin
            if (status.out_free) begin
               cmd.ld_arg = 1'b1;
               state_in   = status.arg_done ? ST_BYTE_RD : ST_ARG_RD;
            end
         end
         ST_BYTE_RD: begin
            state_in = ST_BYTE_OUT;
         end
         ST_BYTE_OUT: begin
            if (status.out_free) begin
               cmd.ld_byte = 1'b1;
               state_in    = status.byte_done ? ST_IDLE : ST_BYTE_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/cmdt_datapath.sv
`timescale 1ns / 1ps
// Datapath: phase and position state, line buffer and argument start memories,
// dump counters and the result register. Depends on cmdt_pkg and cmdt_ram.

module cmdt_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cmdt_pkg::ctl_cmd_type                   cmd,
   output cmdt_pkg::dp_status_type                 status,
   input  logic [cmdt_pkg::BYTE_W-1:0]             req_rx_byte,
   input  logic                                    csr_wr_en,
   input  logic                                    csr_wr_data,
   input  logic                                    rsp_stall,
   output logic                                    rsp_valid,
   output logic [cmdt_pkg::KIND_W-1:0]             rsp_kind,
   output logic [cmdt_pkg::BYTE_W-1:0]             rsp_data_byte,
   output logic [cmdt_pkg::OFFSET_W-1:0]           rsp_offset,
   output logic [cmdt_pkg::COUNT_W-1:0]            rsp_arg_count,
   output logic                                    rsp_error_code,
   output logic                                    rsp_last
);

   import cmdt_pkg::*;

   // Control state
   logic               echo_en_ff;
   phase_type          phase_ff;
   phase_type          phase_in;
   logic [POS_W-1:0]   wpos_ff;
   logic [POS_W-1:0]   wpos_in;
   logic [AC_W-1:0]    aidx_ff;
   logic [AC_W-1:0]    aidx_in;
   logic               err_pend_ff;
   err_type            err_code_ff;
   logic               dump_pend_ff;
   logic [COUNT_W-1:0] dump_cnt_ff;
   logic [POS_W-1:0]   dump_len_ff;
   logic [AC_W-1:0]    argi_ff;
   logic [POS_W-1:0]   bytei_ff;
   logic               rsp_valid_ff;

   // Payload
   logic [BYTE_W-1:0]   byte_ff;
   kind_type            kind_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                err_ff;
   logic                last_ff;

   // Evaluation terms
   logic               is_sp;
   logic               is_cr;
   logic               is_lf;
   logic               eol;
   logic               do_store;
   logic               do_start;
   logic               do_dump;
   logic [BYTE_W-1:0]  store_val;
   logic [AC_W-1:0]    aidx_inc;
   logic               arg_ovf;
   logic               arg_wr;
   logic [POS_W-1:0]   pos_mid;
   logic [AC_W-1:0]    aidx_mid;
   logic               buf_ovf;
   logic               buf_wr;
   logic               dump_go;
   logic               err_go;
   err_type            err_code;

   // Memory read data and dump flags
   logic [BYTE_W-1:0]   buf_rd;
   logic [POS_W-1:0]    arg_rd;
   logic [OFFSET_W-1:0] arg_off;
   logic                arg_done;
   logic                byte_done;
   logic                out_free;

   assign is_sp = (byte_ff == CH_SPACE);
   assign is_cr = (byte_ff == CH_CR);
   assign is_lf = (byte_ff == CH_LF);
   assign eol   = is_cr || is_lf;

   // Decode the byte against the current phase
   always_comb begin
      do_store  = 1'b0;
      do_start  = 1'b0;
      do_dump   = 1'b0;
      store_val = byte_ff;
      phase_in  = phase_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (eol) begin
               do_dump  = is_lf;
               phase_in = PH_ENDL;
            end else if (!is_sp) begin
               do_start = 1'b1;
               do_store = 1'b1;
               phase_in = PH_TOKEN;
            end
         end
         PH_ENDL: begin
            if (is_sp) begin
               phase_in = PH_SPACE;
            end else if (is_lf) begin
               do_dump = 1'b1;
            end else if (!is_cr) begin
               do_store = 1'b1;
               phase_in = PH_TOKEN;
            end
         end
         default: begin
            if (is_sp) begin
               do_store  = 1'b1;
               store_val = CH_NUL;
               phase_in  = PH_SPACE;
            end else if (eol) begin
               do_dump  = is_lf;
               phase_in = PH_ENDL;
            end else begin
               do_store = 1'b1;
            end
         end
      endcase
   end

   // Start a new argument, then store a byte, then check for a dump
   always_comb begin
      aidx_inc = aidx_ff + AC_W'(1);
      arg_ovf  = do_start && (aidx_inc >= AC_W'(MAX_ARGS));
      arg_wr   = do_start && !arg_ovf;
      pos_mid  = arg_ovf ? '0 : wpos_ff;
      if (!do_start) begin
         aidx_mid = aidx_ff;
      end else if (arg_ovf) begin
         aidx_mid = '0;
      end else begin
         aidx_mid = aidx_inc;
      end
      buf_ovf  = do_store && (pos_mid == POS_W'(MAX_LEN));
      buf_wr   = do_store && !buf_ovf;
      dump_go  = do_dump && (wpos_ff != '0);
      err_go   = arg_ovf || buf_ovf;
      err_code = buf_ovf ? ERR_LINE_LONG : ERR_ARGS_MANY;
      if (dump_go || buf_ovf) begin
         wpos_in = '0;
         aidx_in = '0;
      end else if (buf_wr) begin
         wpos_in = pos_mid + POS_W'(1);
         aidx_in = aidx_mid;
      end else begin
         wpos_in = pos_mid;
         aidx_in = aidx_mid;
      end
   end

   // Line buffer
   cmdt_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (cmd.eval && buf_wr),
      .wr_addr (pos_mid[LB_AW-1:0]),
      .wr_data (store_val),
      .rd_addr (bytei_ff[LB_AW-1:0]),
      .rd_data (buf_rd)
   );

   // Argument start offsets; entry zero is never written, and arg_off forces its offset to zero
   cmdt_ram #(
      .WIDTH (POS_W),
      .DEPTH (MAX_ARGS)
   ) u_arg_start (
      .clock   (clock),
      .wr_en   (cmd.eval && arg_wr),
      .wr_addr (aidx_inc[AS_AW-1:0]),
      .wr_data (wpos_ff),
      .rd_addr (argi_ff[AS_AW-1:0]),
      .rd_data (arg_rd)
   );

   assign arg_off   = (argi_ff == '0) ? '0 : OFFSET_W'(arg_rd);
   assign arg_done  = ((COUNT_W'(argi_ff) + COUNT_W'(1)) == dump_cnt_ff);
   assign byte_done = ((bytei_ff + POS_W'(1)) == dump_len_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Echo enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         echo_en_ff <= csr_wr_data;
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   // Tokenizer state, pending results and dump counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         wpos_ff      <= '0;
         aidx_ff      <= '0;
         err_pend_ff  <= 1'b0;
         dump_pend_ff <= 1'b0;
         argi_ff      <= '0;
         bytei_ff     <= '0;
      end else if (cmd.eval) begin
         phase_ff     <= phase_in;
         wpos_ff      <= wpos_in;
         aidx_ff      <= aidx_in;
         err_pend_ff  <= err_go;
         dump_pend_ff <= dump_go;
         argi_ff      <= '0;
         bytei_ff     <= '0;
      end else begin
         if (cmd.ld_arg) begin
            argi_ff <= argi_ff + AC_W'(1);
         end
         if (cmd.ld_byte) begin
            bytei_ff <= bytei_ff + POS_W'(1);
         end
      end
   end

   // Snapshot of the command being dumped
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         err_code_ff <= err_code;
         dump_cnt_ff <= COUNT_W'(aidx_ff) + COUNT_W'(1);
         dump_len_ff <= wpos_ff;
      end
   end

   // Result valid: set on load, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.ld_echo || cmd.ld_err || cmd.ld_arg || cmd.ld_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.ld_echo) begin
         kind_ff   <= KIND_ECHO;
         data_ff   <= byte_ff;
         offset_ff <= '0;
         count_ff  <= '0;
         err_ff    <= 1'b0;
         last_ff   <= !err_pend_ff && !dump_pend_ff;
      end else if (cmd.ld_err) begin
         kind_ff   <= KIND_ERROR;
         data_ff   <= '0;
         offset_ff <= '0;
         count_ff  <= '0;
         err_ff    <= err_code_ff;
         last_ff   <= 1'b1;
      end else if (cmd.ld_arg) begin
         kind_ff   <= KIND_ARG;
         data_ff   <= '0;
         offset_ff <= arg_off;
         count_ff  <= dump_cnt_ff;
         err_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else if (cmd.ld_byte) begin
         kind_ff   <= KIND_BYTE;
         data_ff   <= buf_rd;
         offset_ff <= '0;
         count_ff  <= dump_cnt_ff;
         err_ff    <= 1'b0;
         last_ff   <= byte_done;
      end
   end

   assign status.echo_en   = echo_en_ff;
   assign status.err_pend  = err_pend_ff;
   assign status.dump_pend = dump_pend_ff;
   assign status.arg_done  = arg_done;
   assign status.byte_done = byte_done;
   assign status.out_free  = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_offset     = offset_ff;
   assign rsp_arg_count  = count_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: rtl/command_line_tokenizer_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  rx_byte
// rsp_      out        rsp_valid/rsp_stall  kind, data_byte, offset, arg_count, error_code, last
// csr_      in         csr_wr_en            wr_data = echo_enable
//
// An item passes through capture, evaluate and the echo slot before the next one is taken,
// and also through the error state, which loads the error result, when it raises an error.
// A line feed that dumps the command then sends arg_count offsets and one result per
// stored byte, each result a memory read and then a load.
// Synchronous active-high reset returns to the token phase with an empty buffer.
// A stalled result holds the sequencer in place; an item waits while req_stall is high.
// Top level: ties cmdt_ctrl to cmdt_datapath. Depends on cmdt_pkg.

module command_line_tokenizer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cmdt_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cmdt_pkg::KIND_W-1:0]       rsp_kind,
   output logic [cmdt_pkg::BYTE_W-1:0]       rsp_data_byte,
   output logic [cmdt_pkg::OFFSET_W-1:0]     rsp_offset,
   output logic [cmdt_pkg::COUNT_W-1:0]      rsp_arg_count,
   output logic                              rsp_error_code,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);

   import cmdt_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequencer
   cmdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tokenizer state, memories and result register
   cmdt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_rx_byte    (req_rx_byte),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: rtl/cmdt_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for command_line_tokenizer_core and the bind that attaches them.
// Depends on cmdt_pkg.

module cmdt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [cmdt_pkg::KIND_W-1:0]       rsp_kind,
   input logic [cmdt_pkg::BYTE_W-1:0]       rsp_data_byte,
   input logic [cmdt_pkg::OFFSET_W-1:0]     rsp_offset,
   input logic [cmdt_pkg::COUNT_W-1:0]      rsp_arg_count,
   input logic                              rsp_error_code,
   input logic                              rsp_last
);

   import cmdt_pkg::*;

   // An accepted item keeps the input closed on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on the cycle after an accepted item");

   // A stalled result holds its valid and payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte)
         && $stable(rsp_offset) && $stable(rsp_arg_count) && $stable(rsp_error_code)
         && $stable(rsp_last))
      else $error("stalled result changed");

   // An error always closes its item; an argument offset never does
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR) |-> rsp_last)
      else $error("error result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ARG) |-> !rsp_last)
      else $error("argument offset marked last");

   // Dumped results carry a nonzero argument count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_ARG) || (rsp_kind == KIND_BYTE)) |-> (rsp_arg_count != '0))
      else $error("dump result with zero argument count");

endmodule

bind command_line_tokenizer_core cmdt_checker u_checker (.*);

FILE: verif/tb_command_line_tokenizer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_line_tokenizer_core: drives received bytes and the
// echo register, predicts every echo, error, offset and buffer result, and checks them.
// Depends on cmdt_pkg and the RTL top level.

module tb_command_line_tokenizer_core;
   import cmdt_pkg::*;

   localparam int LINE_PLAIN = 0;
   localparam int LINE_LONG  = 1;
   localparam int LINE_MANY  = 2;
   localparam int LINE_NOISE = 3;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 100;
   localparam int DRAIN_LIMIT      = 200000;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  arg_count;
      logic                error_code;
      logic                last;
   } tok_result_type;

   // Predicts the results of each accepted byte and matches them against the outputs
   class cmdline_scoreboard;
      bit                  echo_on;
      phase_type           cur_phase = PH_TOKEN;
      bit [BYTE_W-1:0]     line_bytes [MAX_LEN];
      int unsigned         fill_pos;
      int unsigned         arg_num;
      bit [OFFSET_W-1:0]   arg_offsets [MAX_ARGS];
      tok_result_type      awaited_results [$];
      tok_result_type      item_results [$];
      int                  errors;

      function void emit_result(kind_type k, bit [BYTE_W-1:0] d, bit [OFFSET_W-1:0] off,
                                bit [COUNT_W-1:0] cnt, err_type e);
         tok_result_type r;
         r.kind       = k;
         r.data_byte  = d;
         r.offset     = off;
         r.arg_count  = cnt;
         r.error_code = e;
         r.last       = 1'b0;
         item_results.push_back(r);
      endfunction

      // Drop the byte and clear the line when the buffer is full
      function void store_byte(bit [BYTE_W-1:0] b);
         if (fill_pos < MAX_LEN) begin
            line_bytes[fill_pos] = b;
            fill_pos++;
         end else begin
            fill_pos = 0;
            arg_num  = 0;
            emit_result(KIND_ERROR, CH_NUL, '0, '0, ERR_LINE_LONG);
         end
      endfunction

      function void open_arg();
         arg_num++;
         if (arg_num >= MAX_ARGS) begin
            fill_pos = 0;
            arg_num  = 0;
            emit_result(KIND_ERROR, CH_NUL, '0, '0, ERR_ARGS_MANY);
         end else begin
            arg_offsets[arg_num] = OFFSET_W'(fill_pos);
         end
      endfunction

      // Offsets first, then the stored bytes; nothing on an empty line
      function void dump_command();
         int unsigned cnt;
         if (fill_pos == 0)
            return;
         cnt = arg_num + 1;
         for (int i = 0; i < cnt && i < MAX_ARGS; i++)
            emit_result(KIND_ARG, CH_NUL, arg_offsets[i], COUNT_W'(cnt), ERR_LINE_LONG);
         for (int i = 0; i < fill_pos && i < MAX_LEN; i++)
            emit_result(KIND_BYTE, line_bytes[i], '0, COUNT_W'(cnt), ERR_LINE_LONG);
         fill_pos = 0;
         arg_num  = 0;
      endfunction

      function void take_rx_byte(bit [BYTE_W-1:0] b);
         bit eol;
         eol = (b == CH_CR) || (b == CH_LF);
         item_results.delete();
         if (echo_on)
            emit_result(KIND_ECHO, b, '0, '0, ERR_LINE_LONG);
         case (cur_phase)
            PH_SPACE: begin
               if (eol) begin
                  if (b == CH_LF)
                     dump_command();
                  cur_phase = PH_ENDL;
               end else if (b != CH_SPACE) begin
                  open_arg();
                  store_byte(b);
                  cur_phase = PH_TOKEN;
               end
            end
            PH_ENDL: begin
               // a plain byte after CR continues the same buffer, no new argument
               if (b == CH_SPACE) begin
                  cur_phase = PH_SPACE;
               end else if (b == CH_LF) begin
                  dump_command();
               end else if (b != CH_CR) begin
                  store_byte(b);
                  cur_phase = PH_TOKEN;
               end
            end
            default: begin
               if (b == CH_SPACE) begin
                  store_byte(CH_NUL);
                  cur_phase = PH_SPACE;
               end else if (eol) begin
                  cur_phase = PH_ENDL;
                  if (b == CH_LF)
                     dump_command();
               end else begin
                  store_byte(b);
               end
            end
         endcase
         if (item_results.size() > 0)
            item_results[item_results.size() - 1].last = 1'b1;
         foreach (item_results[i])
            awaited_results.push_back(item_results[i]);
      endfunction

      function void compare_field(string name, logic [BYTE_W-1:0] want_v,
                                  logic [BYTE_W-1:0] got_v);
         if (got_v !== want_v) begin
            $error("%s: expected %0d, actual %0d", name, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_result(tok_result_type got);
         tok_result_type want;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: kind %0d data_byte %0d", got.kind, got.data_byte);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("kind", BYTE_W'(want.kind), BYTE_W'(got.kind));
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("offset", BYTE_W'(want.offset), BYTE_W'(got.offset));
         compare_field("arg_count", BYTE_W'(want.arg_count), BYTE_W'(got.arg_count));
         compare_field("error_code", BYTE_W'(want.error_code), BYTE_W'(got.error_code));
         compare_field("last", BYTE_W'(want.last), BYTE_W'(got.last));
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte    = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [BYTE_W-1:0]   rsp_data_byte;
   logic [OFFSET_W-1:0] rsp_offset;
   logic [COUNT_W-1:0]  rsp_arg_count;
   logic                rsp_error_code;
   logic                rsp_last;
   logic                csr_wr_en      = 1'b0;
   logic                csr_wr_data    = 1'b0;

   cmdline_scoreboard   sb;
   tok_result_type      seen_result;
   int unsigned         items_sent     = 0;
   int unsigned         stall_run_left = 0;
   bit                  steady_run     = 1'b0;
   bit                  hold_off_req   = 1'b0;

   // Short hand-picked lines: basic split, empty LF, byte extremes, CR quirks
   bit [BYTE_W-1:0] directed_bytes [0:24] = '{
      8'h61, CH_SPACE, 8'h62, CH_LF,
      CH_LF,
      8'h00, 8'hFF, CH_CR, 8'h7E, CH_LF,
      CH_SPACE, 8'h71, CH_CR, CH_SPACE, 8'h72, CH_LF,
      8'h80, 8'h01, CH_SPACE, CH_LF,
      8'h7A, CH_SPACE, CH_CR, 8'h79, CH_LF
   };

   command_line_tokenizer_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_offset     (rsp_offset),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit [BYTE_W-1:0] token_char();
      bit [BYTE_W-1:0] c;
      do
         c = BYTE_W'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_CR || c == CH_LF);
      return c;
   endfunction

   function automatic bit [BYTE_W-1:0] noise_char();
      case ($urandom_range(0, 9))
         0, 1:    return CH_SPACE;
         2:       return CH_CR;
         3:       return CH_LF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Receiver: random stall runs, a long hold-off on request, none in steady stretches
   always @(negedge clock) begin
      if (hold_off_req) begin
         rsp_stall <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(negedge clock);
         rsp_stall <= 1'b0;
         hold_off_req   = 1'b0;
         stall_run_left = 0;
      end else if (steady_run) begin
         rsp_stall <= 1'b0;
      end else if (stall_run_left > 0) begin
         stall_run_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_run_left = pick_gap();
      end
   end

   // Check every result taken at a rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.kind       = rsp_kind;
         seen_result.data_byte  = rsp_data_byte;
         seen_result.offset     = rsp_offset;
         seen_result.arg_count  = rsp_arg_count;
         seen_result.error_code = rsp_error_code;
         seen_result.last       = rsp_last;
         sb.check_result(seen_result);
      end
   end

   // Offer one byte, hold it until taken, then maybe idle
   task automatic send_rx_byte(bit [BYTE_W-1:0] b);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
      sb.take_rx_byte(b);
      items_sent++;
      @(negedge clock);
      gap = steady_run ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_line(int mode);
      bit [BYTE_W-1:0] seq [$];
      int              n_args;
      int unsigned     ending;
      case (mode)
         LINE_LONG: begin
            repeat (MAX_LEN + $urandom_range(1, 4)) seq.push_back(token_char());
            seq.push_back(CH_LF);
         end
         LINE_MANY: begin
            n_args = $urandom_range(MAX_ARGS - 1, MAX_ARGS + 2);
            for (int a = 0; a < n_args; a++) begin
               if (a > 0)
                  seq.push_back(CH_SPACE);
               repeat ($urandom_range(1, 2)) seq.push_back(token_char());
            end
            seq.push_back(CH_LF);
         end
         LINE_NOISE: begin
            repeat ($urandom_range(3, 10)) seq.push_back(noise_char());
         end
         default: begin
            if ($urandom_range(0, 4) == 0)
               seq.push_back(CH_SPACE);
            n_args = $urandom_range(1, 5);
            for (int a = 0; a < n_args; a++) begin
               if (a > 0) begin
                  if ($urandom_range(0, 9) == 0) begin
                     seq.push_back(CH_CR);
                     seq.push_back(CH_SPACE);
                  end else begin
                     repeat ($urandom_range(1, 2)) seq.push_back(CH_SPACE);
                  end
               end
               repeat ($urandom_range(1, 6)) seq.push_back(token_char());
            end
            ending = $urandom_range(0, 9);
            if (ending < 3)
               seq.push_back(CH_CR);
            else if (ending == 3)
               seq.push_back(CH_SPACE);
            seq.push_back(CH_LF);
         end
      endcase
      steady_run = ($urandom_range(0, 4) == 0);
      foreach (seq[i])
         send_rx_byte(seq[i]);
      steady_run = 1'b0;
   endtask

   task automatic send_random_lines(int unsigned count);
      int unsigned target;
      int unsigned r;
      target = items_sent + count;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 65)
            send_line(LINE_PLAIN);
         else if (r < 75)
            send_line(LINE_LONG);
         else if (r < 85)
            send_line(LINE_MANY);
         else
            send_line(LINE_NOISE);
      end
   endtask

   // Drop valid, wait for every awaited result, then let the block go quiet
   task automatic settle_block();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_echo(bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.echo_on = value;
   endtask

   initial begin
      sb = new();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_echo(1'b0);
      foreach (directed_bytes[i])
         send_rx_byte(directed_bytes[i]);
      settle_block();

      // Echo on: overflow cases first, then a long receiver hold-off
      write_echo(1'b1);
      send_line(LINE_LONG);
      send_line(LINE_MANY);
      hold_off_req = 1'b1;
      send_line(LINE_PLAIN);
      send_random_lines(10);
      settle_block();

      write_echo(1'b0);
      send_random_lines(15);
      settle_block();

      write_echo(1'b1);
      send_random_lines(10);
      settle_block();

      if (sb.pending() != 0) begin
         $error("%0d expected results never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("tb_command_line_tokenizer_core: done, clean");
      else
         $display("tb_command_line_tokenizer_core: done, errors");
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #20ms;
      $display("tb_command_line_tokenizer_core: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
rtl/cmdt_pkg.sv
rtl/cmdt_ram.sv
rtl/cmdt_ctrl.sv
rtl/cmdt_datapath.sv
rtl/command_line_tokenizer_core.sv
rtl/cmdt_checker.sv
verif/tb_command_line_tokenizer_core.sv
